// File: design/ttf_pkg.sv
// shared types and constants for the thermistor temperature filter
`timescale 1ns / 1ps
`default_nettype none
package ttf_pkg;

    localparam int ADC_W          = 10;
    localparam int CENTI_W        = 16;
    localparam int MUL_W          = 32;
    localparam int MUL_DIG        = 4;
    localparam int MUL_STEPS      = MUL_W / MUL_DIG;
    localparam int DVD_W          = 58;
    localparam int DVS_W          = 45;
    localparam int LOG_FRAC       = 20;
    localparam int LOG_W          = 25;
    localparam int RING_DEPTH_DEF = 16;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [CENTI_W-1:0] CENTI_LOW  = -16'sd7000;
    localparam logic signed [CENTI_W-1:0] CENTI_HIGH = 16'sd20000;

    typedef enum logic [2:0] {
        CFG_BETA   = 3'd0,
        CFG_R0     = 3'd1,
        CFG_T0     = 3'd2,
        CFG_SERIES = 3'd3,
        CFG_AUX    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_W-1:0] adc_main;
        logic [ADC_W-1:0] adc_aux;
    } t_in;

    typedef struct packed {
        logic signed [CENTI_W-1:0] sample_centi;
        logic                      accepted;
        logic signed [CENTI_W-1:0] mean_centi;
        logic signed [CENTI_W-1:0] ewma_centi;
    } t_out;

endpackage
`default_nettype wire

// File: design/thermistor_temperature_filter_top.sv
// thermistor temperature filter top level: sequencer, ring store and averages
// One beat in gives one beat out. A reading at zero or full scale skips the arithmetic
// and goes straight to the output stage; a normal reading runs through the serial
// multiplier (two products, 20 squarings for each of two logarithms after a leading-one
// shift, then three more products) and the one-bit-per-cycle divider, which runs
// for the temperature quotient and again for the average and the mean
// when the sample is stored. The next beat is taken while a result waits on the output.
`timescale 1ns / 1ps
`default_nettype none
module thermistor_temperature_filter_top import ttf_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W  = $clog2(RING_DEPTH * 20000 + 1) + 1;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL_A = 13'b0000000000010,
        S_MUL_B = 13'b0000000000100,
        S_NORM  = 13'b0000000001000,
        S_SQR   = 13'b0000000010000,
        S_LNMUL = 13'b0000000100000,
        S_TLMUL = 13'b0000001000000,
        S_BTMUL = 13'b0000010000000,
        S_DIV   = 13'b0000100000000,
        S_UPD   = 13'b0001000000000,
        S_EWMA  = 13'b0010000000000,
        S_MEAN  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state;
    logic [15:0]         r_beta;
    logic [9:0]          r_r0;
    logic signed [7:0]   r_t0;
    logic [14:0]         r_series;
    logic                r_aux;
    logic                r_issued;
    logic [10:0]         r_s;
    logic [10:0]         r_fs;
    logic [30:0]         r_a;
    logic [30:0]         r_b;
    logic [30:0]         r_y;
    logic [4:0]          r_k;
    logic [LOG_FRAC-1:0] r_frac;
    logic [4:0]          r_cnt;
    logic                r_pass;
    logic [LOG_W-1:0]    r_la;
    logic [LOG_W-1:0]    r_lb;
    logic                r_neg;
    logic [LOG_W-1:0]    r_lq;
    logic [40:0]         r_tl;
    logic [31:0]         r_bt;
    logic signed [CENTI_W-1:0] r_centi;
    logic                r_ok;
    logic signed [23:0]  r_ewma;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [CENTI_W-1:0] r_mean;
    logic [SLOT_W-1:0]   r_slot;
    logic signed [CENTI_W-1:0] r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_vld;
    logic signed [CENTI_W-1:0] r_rd;
    logic                r_rd_vld;
    logic                r_ovalid;
    t_out                r_odata;

    logic [10:0]          in_s;
    logic [10:0]          in_full;
    logic signed [25:0]   d2;
    logic [LOG_W-1:0]     mag;
    logic signed [16:0]   t0k_s;
    logic [15:0]          t0k;
    logic [19:0]          r0k;
    logic [22:0]          b100;
    logic signed [44:0]   tl_s;
    logic signed [44:0]   den;
    logic                 den_pos;
    logic [37:0]          bt100;
    logic signed [27:0]   ew_num;
    logic [27:0]          ew_mag;
    logic [SUM_W-1:0]     sum_mag;
    logic [23:0]          e_abs;
    logic [15:0]          e_sh;
    logic signed [CENTI_W-1:0] ewma_out;

    logic                 mul_start;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic                 mul_done;
    logic [2*MUL_W-1:0]   mul_p;
    logic [31:0]          sq_t;
    logic [LOG_FRAC-1:0]  n_frac;

    logic                 div_start;
    logic [DVD_W-1:0]     div_n;
    logic [DVS_W-1:0]     div_d;
    logic                 div_done;
    logic [DVD_W-1:0]     div_q;
    logic [DVS_W-1:0]     div_r;
    logic                 q_big;
    logic [15:0]          qlo;
    logic                 rnz;
    logic signed [16:0]   w;
    logic signed [16:0]   w_adj;
    logic                 ok_d;
    logic signed [CENTI_W-1:0] centi_d;
    logic signed [SUM_W-1:0]   n_sum;

    assign in_s    = r_aux ? 11'(i_in_data.adc_main) + 11'(i_in_data.adc_aux)
                           : 11'(i_in_data.adc_main);
    assign in_full = r_aux ? 11'd2046 : 11'd1023;

    assign d2      = $signed({1'b0, r_la}) - $signed({1'b0, r_lb});
    assign mag     = d2[25] ? LOG_W'(-d2) : d2[LOG_W-1:0];
    assign t0k_s   = 17'sd27315 + 17'(r_t0) * 17'sd100;
    assign t0k     = t0k_s[15:0];
    assign r0k     = 20'(r_r0) * 20'd1000;
    assign b100    = 23'(r_beta) * 23'd100;
    assign tl_s    = $signed({4'b0, r_tl});
    assign den     = $signed({2'b0, b100, 20'b0}) + (r_neg ? -tl_s : tl_s);
    assign den_pos = !den[44] && (den != '0);
    assign bt100   = 38'(r_bt) * 38'd100;

    assign ew_num  = $signed({{4{r_centi[15]}}, r_centi, 8'b0})
                   + (28'(r_ewma) <<< 3) + 28'(r_ewma);
    assign ew_mag  = ew_num[27] ? 28'(-ew_num) : 28'(ew_num);
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign e_abs   = r_ewma[23] ? 24'(-r_ewma) : 24'(r_ewma);
    assign e_sh    = e_abs[23:8];
    assign ewma_out = r_ewma[23] ? -$signed(e_sh) : $signed(e_sh);

    // multiplier operands
    assign mul_start = (r_state inside {S_MUL_A, S_MUL_B, S_SQR, S_LNMUL, S_TLMUL, S_BTMUL})
                     && !r_issued;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_A: begin mul_a = MUL_W'(r_series); mul_b = MUL_W'(r_fs);   end
            S_MUL_B: begin mul_a = MUL_W'(r0k);      mul_b = MUL_W'(r_s);    end
            S_SQR:   begin mul_a = MUL_W'(r_y);      mul_b = MUL_W'(r_y);    end
            S_LNMUL: begin mul_a = MUL_W'(mag);      mul_b = LN2_Q32;        end
            S_TLMUL: begin mul_a = MUL_W'(t0k);      mul_b = MUL_W'(r_lq);   end
            S_BTMUL: begin mul_a = MUL_W'(r_beta);   mul_b = MUL_W'(t0k);    end
            default: begin mul_a = '0;               mul_b = '0;             end
        endcase
    end

    // divider operands
    assign div_start = (r_state inside {S_DIV, S_EWMA, S_MEAN}) && !r_issued;
    always_comb begin
        div_n = '0;
        div_d = '0;
        case (r_state)
            S_DIV:   begin div_n = {bt100, 20'b0};     div_d = den[DVS_W-1:0];      end
            S_EWMA:  begin div_n = DVD_W'(ew_mag);     div_d = DVS_W'(10);          end
            S_MEAN:  begin div_n = DVD_W'(sum_mag);    div_d = DVS_W'(RING_DEPTH);  end
            default: begin div_n = '0;                 div_d = '0;                  end
        endcase
    end

    assign sq_t   = mul_p[61:30];
    assign n_frac = {r_frac[LOG_FRAC-2:0], sq_t[31]};

    assign q_big   = (|div_q[DVD_W-1:16]) || (div_q[15:0] >= 16'd47315);
    assign qlo     = div_q[15:0];
    assign rnz     = div_r != '0;
    assign w       = $signed({1'b0, qlo}) - 17'sd27315;
    assign w_adj   = (w < 0 && rnz) ? w + 17'sd1 : w;
    assign ok_d    = !q_big && ((qlo > 16'd20315) || (qlo == 16'd20315 && rnz));
    assign centi_d = q_big ? CENTI_HIGH
                   : (w_adj < 17'(CENTI_LOW)) ? CENTI_LOW : w_adj[15:0];

    assign n_sum = r_sum + SUM_W'(r_centi) - (r_rd_vld ? SUM_W'(r_rd) : SUM_W'(0));

    ttf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    ttf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // ring store
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_ring[r_slot] <= r_centi;
        end
        r_rd <= r_ring[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_beta   <= 16'd3950;
            r_r0     <= 10'd10;
            r_t0     <= 8'sd25;
            r_series <= 15'd10000;
            r_aux    <= 1'b0;
            r_issued <= 1'b0;
            r_ewma   <= '0;
            r_sum    <= '0;
            r_mean   <= '0;
            r_slot   <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[r_slot];
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BETA:   r_beta   <= i_cfg_data;
                    CFG_R0:     r_r0     <= i_cfg_data[9:0];
                    CFG_T0:     r_t0     <= $signed(i_cfg_data[7:0]);
                    CFG_SERIES: r_series <= i_cfg_data[14:0];
                    CFG_AUX:    r_aux    <= i_cfg_data[0];
                    default:    ;
                endcase
            end
            if (mul_start || div_start) begin
                r_issued <= 1'b1;
            end
            if (mul_done || div_done) begin
                r_issued <= 1'b0;
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ok <= 1'b0;
                        if (in_s == '0 || r_r0 == '0) begin
                            r_centi <= CENTI_LOW;
                            r_state <= S_DONE;
                        end else if (in_s >= in_full || r_series == '0) begin
                            r_centi <= CENTI_HIGH;
                            r_state <= S_DONE;
                        end else begin
                            r_s     <= in_s;
                            r_fs    <= in_full - in_s;
                            r_state <= S_MUL_A;
                        end
                    end
                end
                S_MUL_A: begin
                    if (mul_done) begin
                        r_a     <= mul_p[30:0];
                        r_state <= S_MUL_B;
                    end
                end
                S_MUL_B: begin
                    if (mul_done) begin
                        r_b     <= mul_p[30:0];
                        r_y     <= r_a;
                        r_k     <= 5'd30;
                        r_pass  <= 1'b0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_y[30]) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= S_SQR;
                    end else begin
                        r_y <= {r_y[29:0], 1'b0};
                        r_k <= r_k - 1'b1;
                    end
                end
                S_SQR: begin
                    if (mul_done) begin
                        r_y    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                        r_frac <= n_frac;
                        r_cnt  <= r_cnt + 1'b1;
                        if (r_cnt == 5'(LOG_FRAC - 1)) begin
                            if (!r_pass) begin
                                r_la    <= {r_k, n_frac};
                                r_y     <= r_b;
                                r_k     <= 5'd30;
                                r_pass  <= 1'b1;
                                r_state <= S_NORM;
                            end else begin
                                r_lb    <= {r_k, n_frac};
                                r_state <= S_LNMUL;
                            end
                        end
                    end
                end
                S_LNMUL: begin
                    if (mul_done) begin
                        r_lq    <= mul_p[56:32];
                        r_neg   <= d2[25];
                        r_state <= S_TLMUL;
                    end
                end
                S_TLMUL: begin
                    if (mul_done) begin
                        r_tl    <= mul_p[40:0];
                        r_state <= S_BTMUL;
                    end
                end
                S_BTMUL: begin
                    if (mul_done) begin
                        r_bt <= mul_p[31:0];
                        if (den_pos) begin
                            r_state <= S_DIV;
                        end else begin
                            r_centi <= CENTI_HIGH;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_centi <= centi_d;
                        r_ok    <= ok_d;
                        r_state <= ok_d ? S_UPD : S_DONE;
                    end
                end
                S_UPD: begin
                    r_sum         <= n_sum;
                    r_vld[r_slot] <= 1'b1;
                    r_slot        <= (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                         : r_slot + 1'b1;
                    r_state       <= S_EWMA;
                end
                S_EWMA: begin
                    if (div_done) begin
                        r_ewma  <= ew_num[27] ? -$signed(div_q[23:0]) : $signed(div_q[23:0]);
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_mean  <= r_sum[SUM_W-1] ? -$signed(div_q[15:0]) : $signed(div_q[15:0]);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_odata.sample_centi <= r_centi;
                        r_odata.accepted     <= r_ok;
                        r_odata.mean_centi   <= r_mean;
                        r_odata.ewma_centi   <= ewma_out;
                        r_ovalid             <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
`default_nettype wire

// File: design/ttf_mul.sv
// shift-add multiplier, one 4-bit digit of the multiplier per cycle
`timescale 1ns / 1ps
`default_nettype none
module ttf_mul import ttf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MUL_W-1:0]     i_a,
    input  logic [MUL_W-1:0]     i_b,
    output logic                 o_done,
    output logic [2*MUL_W-1:0]   o_prod
);

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic [MUL_W-1:0]         r_x;
    logic [2*MUL_W-1:0]       r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [MUL_W+MUL_DIG-1:0] n_sum;

    assign n_sum = (MUL_W+MUL_DIG)'(r_acc[2*MUL_W-1:MUL_W])
                 + (MUL_W+MUL_DIG)'(r_x) * (MUL_W+MUL_DIG)'(r_acc[MUL_DIG-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_x    <= i_a;
                r_acc  <= {{MUL_W{1'b0}}, i_b};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {n_sum, r_acc[MUL_W-1:MUL_DIG]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// File: design/ttf_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ttf_div import ttf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   n_trial;
    logic             n_ge;

    assign n_trial = {r_rem, r_q[DVD_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_ge ? DVS_W'(n_trial - {1'b0, r_d}) : n_trial[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire
